### rtl/signal_pending_delivery_engine_top_assert.svh
// ----------------------------------------------------------------------------
// Signal pending delivery engine assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef SIGNAL_PENDING_DELIVERY_ENGINE_TOP_ASSERT_SVH
`define SIGNAL_PENDING_DELIVERY_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPDE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spde same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPDE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spde next-cycle check failed");

`endif

### rtl/spde_pkg.sv
// ----------------------------------------------------------------------------
// Signal pending delivery engine package
// Types, codes and helper functions shared by the engine's modules.
// ----------------------------------------------------------------------------
package spde_pkg;

	localparam int ID_COUNT     = 64;
	localparam int SIGNAL_COUNT = 64;
	localparam int ACT_DEPTH    = ID_COUNT * SIGNAL_COUNT;
	localparam int ACT_AW       = $clog2(ACT_DEPTH);

	typedef logic [2:0] op_t;
	localparam op_t OP_SET_ACTION  = 3'd0;
	localparam op_t OP_GET_ACTION  = 3'd1;
	localparam op_t OP_SEND        = 3'd2;
	localparam op_t OP_SET_MASK    = 3'd3;
	localparam op_t OP_GET_PENDING = 3'd4;
	localparam op_t OP_TAKE        = 3'd5;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_REJECT  = 3'd1;
	localparam status_t ST_NONE    = 3'd2;
	localparam status_t ST_FULL    = 3'd3;
	localparam status_t ST_IGNORED = 3'd4;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_INVALID = 2'd0;
	localparam mode_t MODE_BLOCK   = 2'd1;
	localparam mode_t MODE_UNBLOCK = 2'd2;
	localparam mode_t MODE_SET     = 2'd3;

	localparam logic CFG_KILL   = 1'b0;
	localparam logic CFG_IGNORE = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FETCH,
		S_EXEC,
		S_SCAN,
		S_QRD,
		S_QCMP,
		S_MRD,
		S_MWR,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [6:0]  kill;
		logic [63:0] ignore;
	} cfg_t;

	typedef struct packed {
		logic [6:0]  sig;
		logic [5:0]  sender;
		logic [31:0] payload;
	} rec_t;

	function automatic logic [63:0] sig_bit(logic [6:0] s);
		logic [6:0] m;
		m = s - 7'd1;
		return 64'd1 << m[5:0];
	endfunction

endpackage

### rtl/signal_pending_delivery_engine_top.sv
// ----------------------------------------------------------------------------
// Signal pending delivery engine
// Handler table, per-thread pending and blocked words and bounded record
// queues, driven by one sequencer over simple dual-port storage.
// ----------------------------------------------------------------------------
// Channel   Handshake                    Payload
// command   start / busy                 operation .. info_payload
// result    done (one-cycle strobe)      status .. taken_payload
// config    psel / penable / pwrite      paddr, pwdata, prdata
//
// A command is accepted when start is high and busy is low. Most operations
// pass through the fetch, execute and finish states, with registered table
// reads. A take adds a byte-wise pending scan, a read and compare per queue
// record examined, and a read and write per record moved up.
// After reset the tables are cleared while busy is high.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module signal_pending_delivery_engine_top #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [5:0]  process_id,
	input  logic [5:0]  thread_id,
	input  logic [6:0]  signal_number,
	input  logic [1:0]  mask_mode,
	input  logic [63:0] operand_word,
	input  logic [31:0] info_payload,
	output logic        done,
	output logic [2:0]  status,
	output logic [63:0] result_word,
	output logic [6:0]  taken_signal,
	output logic [5:0]  taken_sender,
	output logic [31:0] taken_payload,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int REC_DEPTH = spde_pkg::ID_COUNT * QUEUE_DEPTH;
	localparam int RAW       = $clog2(REC_DEPTH);
	localparam int RECW      = $bits(spde_pkg::rec_t);

	spde_pkg::cfg_t   cfg;
	spde_pkg::state_t state_q, state_d;

	logic [spde_pkg::ACT_AW-1:0] clr_q;
	logic                        done_q;

	spde_pkg::op_t   op_q;
	logic [5:0]      pid_q;
	logic [5:0]      idx_q;
	logic [6:0]      sig_q;
	spde_pkg::mode_t mode_q;
	logic [63:0]     word_q;
	logic [31:0]     pay_q;
	logic [spde_pkg::ACT_AW-1:0] slot_q;
	logic [63:0]     sel_q;
	logic [2:0]      chunk_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   j_q;
	logic            hit_q;

	spde_pkg::status_t status_q;
	logic [63:0]       result_q;
	logic [6:0]        taken_sig_q;
	logic [5:0]        taken_sender_q;
	logic [31:0]       taken_payload_q;

	logic                        act_we;
	logic [spde_pkg::ACT_AW-1:0] act_wa;
	logic [63:0]                 act_wd;
	logic [63:0]                 act_rd;
	logic                        pend_we;
	logic [63:0]                 pend_wd;
	logic [63:0]                 pend_rd;
	logic                        mask_we;
	logic [63:0]                 mask_wd;
	logic [63:0]                 mask_rd;
	logic                        cnt_we;
	logic [CW-1:0]               cnt_wd;
	logic [CW-1:0]               cnt_rd;
	logic [5:0]                  small_wa;
	logic                        rec_we;
	logic [RAW-1:0]              rec_wa;
	logic [RAW-1:0]              rec_ra;
	spde_pkg::rec_t              rec_wd;
	spde_pkg::rec_t              rec_rd;
	logic [RECW-1:0]             rec_rd_raw;

	logic        sig_ok;
	logic        kill_ok;
	logic        ignored;
	logic        full;
	logic [63:0] set_w;
	logic [63:0] new_mask;
	logic [7:0]  scan_byte;
	logic        found;
	logic [2:0]  low_bit;
	logic [6:0]  found_sig;
	logic        rec_match;

	function automatic logic [RAW-1:0] rec_addr(logic [5:0] t, logic [CW-1:0] k);
		return RAW'(int'(t) * QUEUE_DEPTH + int'(k));
	endfunction

	spde_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	spde_ram #(.DEPTH(spde_pkg::ACT_DEPTH), .WIDTH(64)) u_act (
		.clk (clk), .we (act_we), .waddr (act_wa), .wdata (act_wd),
		.raddr (slot_q), .rdata (act_rd)
	);

	spde_ram #(.DEPTH(spde_pkg::ID_COUNT), .WIDTH(64)) u_pend (
		.clk (clk), .we (pend_we), .waddr (small_wa), .wdata (pend_wd),
		.raddr (idx_q), .rdata (pend_rd)
	);

	spde_ram #(.DEPTH(spde_pkg::ID_COUNT), .WIDTH(64)) u_mask (
		.clk (clk), .we (mask_we), .waddr (small_wa), .wdata (mask_wd),
		.raddr (idx_q), .rdata (mask_rd)
	);

	spde_ram #(.DEPTH(spde_pkg::ID_COUNT), .WIDTH(CW)) u_cnt (
		.clk (clk), .we (cnt_we), .waddr (small_wa), .wdata (cnt_wd),
		.raddr (idx_q), .rdata (cnt_rd)
	);

	spde_ram #(.DEPTH(REC_DEPTH), .WIDTH(RECW)) u_rec (
		.clk (clk), .we (rec_we), .waddr (rec_wa), .wdata (rec_wd),
		.raddr (rec_ra), .rdata (rec_rd_raw)
	);

	assign rec_rd = spde_pkg::rec_t'(rec_rd_raw);

	always_comb begin
		sig_ok   = (sig_q >= 7'd1) && (sig_q <= 7'(spde_pkg::SIGNAL_COUNT));
		kill_ok  = (cfg.kill >= 7'd1) && (cfg.kill <= 7'd64);
		ignored  = (act_rd == cfg.ignore);
		full     = (cnt_rd >= CW'(QUEUE_DEPTH));
		set_w    = word_q & ~(kill_ok ? spde_pkg::sig_bit(cfg.kill) : 64'd0);
		case (mode_q)
			spde_pkg::MODE_BLOCK:   new_mask = mask_rd | set_w;
			spde_pkg::MODE_UNBLOCK: new_mask = mask_rd & ~set_w;
			spde_pkg::MODE_SET:     new_mask = set_w;
			default:                new_mask = mask_rd;
		endcase
		scan_byte = sel_q[{chunk_q, 3'b000} +: 8];
		found     = 1'b0;
		low_bit   = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (scan_byte[k]) begin
				found   = 1'b1;
				low_bit = 3'(k);
			end
		end
		found_sig = {1'b0, chunk_q, low_bit} + 7'd1;
		rec_match = (rec_rd.sig == taken_sig_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			spde_pkg::S_CLEAR: begin
				if (clr_q == '1) state_d = spde_pkg::S_IDLE;
			end
			spde_pkg::S_IDLE: begin
				if (start) state_d = spde_pkg::S_FETCH;
			end
			spde_pkg::S_FETCH: state_d = spde_pkg::S_EXEC;
			spde_pkg::S_EXEC: begin
				if (op_q == spde_pkg::OP_TAKE && (pend_rd & word_q) != 64'd0) begin
					state_d = spde_pkg::S_SCAN;
				end else begin
					state_d = spde_pkg::S_FIN;
				end
			end
			spde_pkg::S_SCAN: begin
				if (found) begin
					state_d = (cnt_rd == '0) ? spde_pkg::S_FIN : spde_pkg::S_QRD;
				end
			end
			spde_pkg::S_QRD: state_d = spde_pkg::S_QCMP;
			spde_pkg::S_QCMP: begin
				if (CW'(i_q + 1'b1) < cnt_rd) begin
					state_d = rec_match ? spde_pkg::S_MRD : spde_pkg::S_QRD;
				end else begin
					state_d = spde_pkg::S_FIN;
				end
			end
			spde_pkg::S_MRD: state_d = spde_pkg::S_MWR;
			spde_pkg::S_MWR: begin
				state_d = (CW'(j_q + 1'b1) < cnt_rd) ? spde_pkg::S_MRD : spde_pkg::S_FIN;
			end
			spde_pkg::S_FIN: state_d = spde_pkg::S_IDLE;
			default: state_d = spde_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		act_we   = 1'b0;
		act_wa   = slot_q;
		act_wd   = word_q;
		pend_we  = 1'b0;
		pend_wd  = pend_rd | spde_pkg::sig_bit(sig_q);
		mask_we  = 1'b0;
		mask_wd  = new_mask;
		cnt_we   = 1'b0;
		cnt_wd   = CW'(cnt_rd + 1'b1);
		small_wa = idx_q;
		rec_we   = 1'b0;
		rec_wa   = rec_addr(idx_q, cnt_rd);
		rec_wd   = '{sig: sig_q, sender: pid_q, payload: pay_q};
		rec_ra   = rec_addr(idx_q, (state_q == spde_pkg::S_MRD) ? j_q : i_q);
		case (state_q)
			spde_pkg::S_CLEAR: begin
				act_we   = 1'b1;
				act_wa   = clr_q;
				act_wd   = 64'd0;
				pend_we  = 1'b1;
				pend_wd  = 64'd0;
				mask_we  = 1'b1;
				mask_wd  = 64'd0;
				cnt_we   = 1'b1;
				cnt_wd   = '0;
				small_wa = clr_q[5:0];
			end
			spde_pkg::S_EXEC: begin
				case (op_q)
					spde_pkg::OP_SET_ACTION: begin
						act_we = sig_ok && (sig_q != cfg.kill);
					end
					spde_pkg::OP_SEND: begin
						if (sig_ok && !ignored) begin
							pend_we = 1'b1;
							rec_we  = !full;
							cnt_we  = !full;
						end
					end
					spde_pkg::OP_SET_MASK: begin
						mask_we = (mode_q != spde_pkg::MODE_INVALID);
					end
					default: begin
					end
				endcase
			end
			spde_pkg::S_SCAN: begin
				pend_we = found;
				pend_wd = pend_rd & ~spde_pkg::sig_bit(found_sig);
			end
			spde_pkg::S_MWR: begin
				rec_we = 1'b1;
				rec_wa = rec_addr(idx_q, CW'(j_q - 1'b1));
				rec_wd = rec_rd;
			end
			spde_pkg::S_FIN: begin
				cnt_we = hit_q;
				cnt_wd = CW'(cnt_rd - 1'b1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spde_pkg::S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == spde_pkg::S_FIN);
			if (state_q == spde_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			spde_pkg::S_IDLE: begin
				if (start) begin
					op_q   <= operation;
					pid_q  <= process_id;
					sig_q  <= signal_number;
					mode_q <= mask_mode;
					word_q <= operand_word;
					pay_q  <= info_payload;
					slot_q <= {process_id, 6'(signal_number - 7'd1)};
					if (operation == spde_pkg::OP_SEND && thread_id == 6'd0) begin
						idx_q <= process_id;
					end else begin
						idx_q <= thread_id;
					end
				end
			end
			spde_pkg::S_EXEC: begin
				status_q        <= spde_pkg::ST_REJECT;
				result_q        <= 64'd0;
				taken_sig_q     <= 7'd0;
				taken_sender_q  <= 6'd0;
				taken_payload_q <= 32'd0;
				hit_q           <= 1'b0;
				sel_q           <= pend_rd & word_q;
				chunk_q         <= 3'd0;
				i_q             <= '0;
				case (op_q)
					spde_pkg::OP_SET_ACTION: begin
						if (sig_ok && (sig_q != cfg.kill)) begin
							status_q <= spde_pkg::ST_OK;
							result_q <= act_rd;
						end
					end
					spde_pkg::OP_GET_ACTION: begin
						if (sig_ok) begin
							status_q <= spde_pkg::ST_OK;
							result_q <= act_rd;
						end
					end
					spde_pkg::OP_SEND: begin
						if (sig_q == 7'd0) begin
							status_q <= spde_pkg::ST_OK;
						end else if (sig_ok) begin
							if (ignored) begin
								status_q <= spde_pkg::ST_IGNORED;
							end else if (full) begin
								status_q <= spde_pkg::ST_FULL;
							end else begin
								status_q <= spde_pkg::ST_OK;
							end
						end
					end
					spde_pkg::OP_SET_MASK: begin
						result_q <= mask_rd;
						if (mode_q != spde_pkg::MODE_INVALID) begin
							status_q <= spde_pkg::ST_OK;
						end
					end
					spde_pkg::OP_GET_PENDING: begin
						result_q <= pend_rd;
						status_q <= spde_pkg::ST_OK;
					end
					spde_pkg::OP_TAKE: begin
						status_q <= ((pend_rd & word_q) == 64'd0) ?
							spde_pkg::ST_NONE : spde_pkg::ST_OK;
					end
					default: begin
					end
				endcase
			end
			spde_pkg::S_SCAN: begin
				chunk_q <= chunk_q + 3'd1;
				if (found) begin
					taken_sig_q <= found_sig;
				end
			end
			spde_pkg::S_QCMP: begin
				if (rec_match) begin
					hit_q           <= 1'b1;
					taken_sender_q  <= rec_rd.sender;
					taken_payload_q <= rec_rd.payload;
					j_q             <= CW'(i_q + 1'b1);
				end else begin
					i_q <= CW'(i_q + 1'b1);
				end
			end
			spde_pkg::S_MWR: begin
				j_q <= CW'(j_q + 1'b1);
			end
			default: begin
			end
		endcase
	end

	assign busy          = (state_q != spde_pkg::S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign result_word   = result_q;
	assign taken_signal  = taken_sig_q;
	assign taken_sender  = taken_sender_q;
	assign taken_payload = taken_payload_q;
	assign pready        = 1'b1;

endmodule

### rtl/spde_ram.sv
// ----------------------------------------------------------------------------
// Signal pending delivery engine RAM
// Single write port, single registered read port storage array.
// ----------------------------------------------------------------------------
module spde_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/spde_cfg.sv
// ----------------------------------------------------------------------------
// Signal pending delivery engine configuration registers
// APB-style register file holding the kill signal and the ignore word.
// ----------------------------------------------------------------------------
module spde_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [63:0]    pwdata,
	output logic [63:0]    prdata,
	output spde_pkg::cfg_t cfg
);

	spde_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kill   <= 7'd9;
			cfg_q.ignore <= 64'd1;
		end else if (psel && penable && pwrite) begin
			case (paddr[3])
				spde_pkg::CFG_KILL: begin
					cfg_q.kill <= pwdata[6:0];
				end
				spde_pkg::CFG_IGNORE: begin
					cfg_q.ignore <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign prdata = (paddr[3] == spde_pkg::CFG_IGNORE) ? cfg_q.ignore : {57'd0, cfg_q.kill};
	assign cfg    = cfg_q;

endmodule

### rtl/spde_checker.sv
// ----------------------------------------------------------------------------
// Signal pending delivery engine port checker
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
`include "signal_pending_delivery_engine_top_assert.svh"

module spde_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] status,
	input logic [6:0] taken_signal
);

	`SPDE_ASSERT_NEXT(a_busy_after_transfer, start && !busy, busy)
	`SPDE_ASSERT_NEXT(a_single_strobe, done, !done)
	`SPDE_ASSERT_SAME(a_status_code, done, status <= spde_pkg::ST_IGNORED)
	`SPDE_ASSERT_SAME(a_taken_only_ok, done && status != spde_pkg::ST_OK, taken_signal == 7'd0)

endmodule

bind signal_pending_delivery_engine_top spde_checker u_spde_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.taken_signal (taken_signal)
);

### dv/signal_pending_delivery_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signal pending delivery engine testbench
// Drives directed and random commands through the start/busy port, programs
// the kill and ignore registers over APB between phases, and compares every
// result transfer with a fixed answer for typed directed commands, else with
// a cycle-free model of the handler, pending and queue tables in the bench.
// ----------------------------------------------------------------------------
module signal_pending_delivery_engine_top_tb;

	localparam int QDEPTH      = 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [3:0] ADDR_KILL   = 4'd0;
	localparam logic [3:0] ADDR_IGNORE = 4'd8;
	localparam spde_pkg::op_t OP_BAD_6 = 3'd6;
	localparam spde_pkg::op_t OP_BAD_7 = 3'd7;

	typedef struct {
		spde_pkg::op_t     op;
		logic [5:0]        pid;
		logic [5:0]        tid;
		logic [6:0]        sig;
		spde_pkg::mode_t   mode;
		logic [63:0]       word;
		logic [31:0]       pay;
		bit                typed;
		spde_pkg::status_t t_status;
		logic [63:0]       t_word;
	} cmd_t;

	typedef struct {
		spde_pkg::status_t status;
		logic [63:0]       word;
		logic [6:0]        tsig;
		logic [5:0]        tsender;
		logic [31:0]       tpay;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  operation = '0;
	logic [5:0]  process_id = '0;
	logic [5:0]  thread_id = '0;
	logic [6:0]  signal_number = '0;
	logic [1:0]  mask_mode = '0;
	logic [63:0] operand_word = '0;
	logic [31:0] info_payload = '0;
	logic        done;
	logic [2:0]  status;
	logic [63:0] result_word;
	logic [6:0]  taken_signal;
	logic [5:0]  taken_sender;
	logic [31:0] taken_payload;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	signal_pending_delivery_engine_top #(.QUEUE_DEPTH(QDEPTH)) uut (.*);

	logic [6:0]  kill_sig;
	logic [63:0] ignore_word;
	logic [63:0] handlers [spde_pkg::ID_COUNT * spde_pkg::SIGNAL_COUNT];
	logic [63:0] pending [spde_pkg::ID_COUNT];
	logic [63:0] blocked [spde_pkg::ID_COUNT];
	logic [6:0]  rec_sig [spde_pkg::ID_COUNT][QDEPTH];
	logic [5:0]  rec_sender [spde_pkg::ID_COUNT][QDEPTH];
	logic [31:0] rec_pay [spde_pkg::ID_COUNT][QDEPTH];
	int          rec_count [spde_pkg::ID_COUNT];

	answer_t awaited [$];
	int      mismatches = 0;
	int      cycles = 0;
	int      idle_pct = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("signal_pending_delivery_engine_top_tb failed");
			$finish;
		end
	end

	function automatic logic [63:0] bit_of(logic [6:0] s);
		logic [6:0] m;
		m = s - 7'd1;
		return 64'd1 << m[5:0];
	endfunction

	function automatic answer_t apply_command(cmd_t c);
		answer_t     a;
		int          slot;
		logic [5:0]  dst;
		logic [63:0] cur;
		logic [63:0] set;
		logic [63:0] sel;
		logic [6:0]  s;
		bit          valid;
		a = '{spde_pkg::ST_REJECT, 64'd0, 7'd0, 6'd0, 32'd0};
		valid = c.sig >= 7'd1 && c.sig <= 7'd64;
		slot = int'(c.pid) * spde_pkg::SIGNAL_COUNT + int'((c.sig - 7'd1) & 7'd63);
		case (c.op)
			spde_pkg::OP_SET_ACTION: if (valid && c.sig != kill_sig) begin
				a.word = handlers[slot];
				handlers[slot] = c.word;
				a.status = spde_pkg::ST_OK;
			end
			spde_pkg::OP_GET_ACTION: if (valid) begin
				a.word = handlers[slot];
				a.status = spde_pkg::ST_OK;
			end
			spde_pkg::OP_SEND: if (c.sig == 7'd0) begin
				a.status = spde_pkg::ST_OK;
			end else if (valid) begin
				dst = (c.tid != 6'd0) ? c.tid : c.pid;
				if (handlers[slot] == ignore_word) begin
					a.status = spde_pkg::ST_IGNORED;
				end else begin
					pending[dst] |= bit_of(c.sig);
					if (rec_count[dst] < QDEPTH) begin
						rec_sig[dst][rec_count[dst]] = c.sig;
						rec_sender[dst][rec_count[dst]] = c.pid;
						rec_pay[dst][rec_count[dst]] = c.pay;
						rec_count[dst]++;
						a.status = spde_pkg::ST_OK;
					end else begin
						a.status = spde_pkg::ST_FULL;
					end
				end
			end
			spde_pkg::OP_SET_MASK: begin
				cur = blocked[c.tid];
				set = c.word;
				a.word = cur;
				if (kill_sig >= 7'd1 && kill_sig <= 7'd64)
					set &= ~bit_of(kill_sig);
				if (c.mode != spde_pkg::MODE_INVALID) begin
					if (c.mode == spde_pkg::MODE_BLOCK)
						cur |= set;
					else if (c.mode == spde_pkg::MODE_UNBLOCK)
						cur &= ~set;
					else
						cur = set;
					blocked[c.tid] = cur;
					a.status = spde_pkg::ST_OK;
				end
			end
			spde_pkg::OP_GET_PENDING: begin
				a.word = pending[c.tid];
				a.status = spde_pkg::ST_OK;
			end
			spde_pkg::OP_TAKE: begin
				sel = pending[c.tid] & c.word;
				if (sel == 64'd0) begin
					a.status = spde_pkg::ST_NONE;
				end else begin
					s = 7'd1;
					while (!sel[0]) begin
						sel >>= 1;
						s++;
					end
					pending[c.tid] &= ~bit_of(s);
					a.tsig = s;
					a.status = spde_pkg::ST_OK;
					for (int i = 0; i < rec_count[c.tid]; i++) begin
						if (rec_sig[c.tid][i] == s) begin
							a.tsender = rec_sender[c.tid][i];
							a.tpay = rec_pay[c.tid][i];
							for (int j = i; j < rec_count[c.tid] - 1; j++) begin
								rec_sig[c.tid][j] = rec_sig[c.tid][j + 1];
								rec_sender[c.tid][j] = rec_sender[c.tid][j + 1];
								rec_pay[c.tid][j] = rec_pay[c.tid][j + 1];
							end
							rec_count[c.tid]--;
							break;
						end
					end
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	always @(posedge clk) begin
		answer_t e;
		if (done) begin
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer, status %0d", status);
			end else begin
				e = awaited.pop_front();
				if (status !== e.status || result_word !== e.word
						|| taken_signal !== e.tsig || taken_sender !== e.tsender
						|| taken_payload !== e.tpay) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %h %0d %0d %h got %0d %h %0d %0d %h",
							e.status, e.word, e.tsig, e.tsender, e.tpay, status,
							result_word, taken_signal, taken_sender, taken_payload);
				end
			end
		end
	end

	task automatic issue(cmd_t c, bit last);
		answer_t a;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= c.op;
		process_id <= c.pid;
		thread_id <= c.tid;
		signal_number <= c.sig;
		mask_mode <= c.mode;
		operand_word <= c.word;
		info_payload <= c.pay;
		do @(posedge clk); while (busy);
		a = apply_command(c);
		if (c.typed)
			a = '{c.t_status, c.t_word, 7'd0, 6'd0, 32'd0};
		awaited.insert(awaited.size(), a);
		if (last)
			start <= 1'b0;
	endtask

	task automatic drain();
		while (awaited.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] addr, logic [63:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_KILL)
			kill_sig = value[6:0];
		else
			ignore_word = value;
		@(posedge clk);
	endtask

	function automatic cmd_t random_command();
		cmd_t c;
		int   pick;
		c.typed = 1'b0;
		c.t_status = spde_pkg::ST_OK;
		c.t_word = '0;
		pick = $urandom_range(99);
		if (pick < 35)      c.op = spde_pkg::OP_SEND;
		else if (pick < 60) c.op = spde_pkg::OP_TAKE;
		else if (pick < 70) c.op = spde_pkg::OP_SET_ACTION;
		else if (pick < 78) c.op = spde_pkg::OP_GET_ACTION;
		else if (pick < 87) c.op = spde_pkg::OP_SET_MASK;
		else if (pick < 97) c.op = spde_pkg::OP_GET_PENDING;
		else                c.op = spde_pkg::op_t'($urandom_range(7));
		c.pid = ($urandom_range(99) < 70) ? 6'($urandom_range(3)) : 6'($urandom);
		c.tid = ($urandom_range(99) < 70) ? 6'($urandom_range(3)) : 6'($urandom);
		pick = $urandom_range(99);
		if (pick < 50)      c.sig = 7'($urandom_range(8, 1));
		else if (pick < 90) c.sig = 7'($urandom_range(64, 1));
		else                c.sig = 7'($urandom);
		c.mode = spde_pkg::mode_t'($urandom_range(3));
		c.word = {$urandom, $urandom};
		if (c.op == spde_pkg::OP_TAKE && $urandom_range(1))
			c.word = '1;
		if (c.op == spde_pkg::OP_SET_ACTION && $urandom_range(3) == 0)
			c.word = ignore_word;
		c.pay = $urandom;
		return c;
	endfunction

	cmd_t directed [] = '{
		'{spde_pkg::OP_GET_ACTION, 6'd0, 6'd0, 7'd1, spde_pkg::MODE_INVALID, 64'd0, 32'd0,
			1, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_GET_PENDING, 6'd0, 6'd5, 7'd0, spde_pkg::MODE_INVALID, 64'd0, 32'd0,
			1, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SET_ACTION, 6'd0, 6'd0, 7'd9, spde_pkg::MODE_INVALID, 64'd5, 32'd0,
			1, spde_pkg::ST_REJECT, 64'd0},
		'{spde_pkg::OP_SET_ACTION, 6'd0, 6'd0, 7'd0, spde_pkg::MODE_INVALID, 64'd5, 32'd0,
			1, spde_pkg::ST_REJECT, 64'd0},
		'{spde_pkg::OP_GET_ACTION, 6'd1, 6'd0, 7'd65, spde_pkg::MODE_INVALID, 64'd0, 32'd0,
			1, spde_pkg::ST_REJECT, 64'd0},
		'{spde_pkg::OP_SEND, 6'd1, 6'd0, 7'd127, spde_pkg::MODE_INVALID, 64'd0, 32'd0,
			1, spde_pkg::ST_REJECT, 64'd0},
		'{OP_BAD_6, 6'd1, 6'd1, 7'd1, spde_pkg::MODE_SET, '1, '1,
			1, spde_pkg::ST_REJECT, 64'd0},
		'{OP_BAD_7, 6'd63, 6'd63, 7'd64, spde_pkg::MODE_SET, '1, '1,
			1, spde_pkg::ST_REJECT, 64'd0},
		'{spde_pkg::OP_SEND, 6'd4, 6'd4, 7'd0, spde_pkg::MODE_INVALID, 64'd0, 32'd9,
			1, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_TAKE, 6'd0, 6'd3, 7'd0, spde_pkg::MODE_INVALID, '1, 32'd0,
			1, spde_pkg::ST_NONE, 64'd0},
		'{spde_pkg::OP_SET_MASK, 6'd0, 6'd3, 7'd0, spde_pkg::MODE_INVALID, '1, 32'd0,
			1, spde_pkg::ST_REJECT, 64'd0},
		'{spde_pkg::OP_SET_ACTION, 6'd63, 6'd0, 7'd64, spde_pkg::MODE_INVALID, '1, 32'd0,
			1, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SET_ACTION, 6'd2, 6'd0, 7'd5, spde_pkg::MODE_INVALID, 64'd1, 32'd0,
			1, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SEND, 6'd2, 6'd0, 7'd5, spde_pkg::MODE_INVALID, 64'd0, 32'd0,
			1, spde_pkg::ST_IGNORED, 64'd0},
		'{spde_pkg::OP_SEND, 6'd7, 6'd0, 7'd64, spde_pkg::MODE_INVALID, 64'd0, '1,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SEND, 6'd1, 6'd7, 7'd1, spde_pkg::MODE_INVALID, 64'd0, 32'h1,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SEND, 6'd7, 6'd0, 7'd3, spde_pkg::MODE_INVALID, 64'd0, 32'h2,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SEND, 6'd63, 6'd7, 7'd3, spde_pkg::MODE_INVALID, 64'd0, 32'h3,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SEND, 6'd7, 6'd0, 7'd2, spde_pkg::MODE_INVALID, 64'd0, 32'h4,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SEND, 6'd7, 6'd0, 7'd2, spde_pkg::MODE_INVALID, 64'd0, 32'h5,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SEND, 6'd7, 6'd0, 7'd2, spde_pkg::MODE_INVALID, 64'd0, 32'h6,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SEND, 6'd7, 6'd0, 7'd2, spde_pkg::MODE_INVALID, 64'd0, 32'h7,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SEND, 6'd7, 6'd0, 7'd60, spde_pkg::MODE_INVALID, 64'd0, 32'h8,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_TAKE, 6'd0, 6'd7, 7'd0, spde_pkg::MODE_INVALID,
			64'h0800_0000_0000_0000, 32'd0, 0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_TAKE, 6'd0, 6'd7, 7'd0, spde_pkg::MODE_INVALID, '1, 32'd0,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SET_MASK, 6'd0, 6'd63, 7'd0, spde_pkg::MODE_SET, '1, 32'd0,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SET_MASK, 6'd0, 6'd63, 7'd0, spde_pkg::MODE_UNBLOCK, 64'h0f, 32'd0,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_SET_MASK, 6'd0, 6'd63, 7'd0, spde_pkg::MODE_BLOCK, 64'h3, 32'd0,
			0, spde_pkg::ST_OK, 64'd0},
		'{spde_pkg::OP_GET_PENDING, 6'd0, 6'd7, 7'd0, spde_pkg::MODE_INVALID, 64'd0, 32'd0,
			0, spde_pkg::ST_OK, 64'd0}
	};

	logic [6:0]  kill_plan [6] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd9, 7'd33};
	logic [63:0] ignore_plan [6] = '{64'd0, '1, 64'd1, 64'd0, 64'h0, 64'd2};

	initial begin
		kill_sig = 7'd9;
		ignore_word = 64'd1;
		for (int i = 0; i < spde_pkg::ID_COUNT * spde_pkg::SIGNAL_COUNT; i++)
			handlers[i] = '0;
		for (int i = 0; i < spde_pkg::ID_COUNT; i++) begin
			pending[i] = '0;
			blocked[i] = '0;
			rec_count[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < directed.size(); i++)
			issue(directed[i], i == directed.size() - 1);
		drain();
		for (int p = 0; p < 6; p++) begin
			write_reg(ADDR_KILL, {57'd0, kill_plan[p]});
			write_reg(ADDR_IGNORE, (p == 5) ? {$urandom, $urandom} : ignore_plan[p]);
			idle_pct = (p < 2) ? 13 : (p < 4) ? 76 : 0;
			for (int n = 0; n < 265; n++)
				issue(random_command(), n == 264);
			drain();
		end
		if (mismatches == 0 && awaited.size() == 0) begin
			$display("signal_pending_delivery_engine_top_tb passed");
		end else begin
			$display("signal_pending_delivery_engine_top_tb failed");
		end
		$finish;
	end

endmodule
